>>> rtl/wpt_pkg.sv
// ----------------------------------------------------------------------------
// wpt_pkg
// Shared types and constants for the wrapping position tracker.
// ----------------------------------------------------------------------------
package wpt_pkg;

    localparam int unsigned SPT_W      = 24;   // steps_per_turn width
    localparam int unsigned AZ_W       = 9;    // azimuth / heading width
    localparam int unsigned OP_W       = 3;
    localparam int unsigned STEPS_W    = 25;   // shortest step count width
    localparam int unsigned REM_W      = 33;   // product / divider remainder
    localparam int unsigned QUOT_W     = 9;    // heading quotient
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned DEG_PER_TURN = 360;

    // azimuth*spt/360 = ((x >> 3) * RECIP_45) >> RECIP_SHIFT, exact for x <= 360*(2^SPT_W - 1)
    localparam int unsigned PROD_W      = 60;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam logic [30:0] RECIP_45    = 31'd1527099484;

    // quotient bits produced by the heading divide
    localparam int unsigned H_STEPS = 9;       // position*360 / spt

    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_FWD  = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK = 3'd2;
    localparam logic [OP_W-1:0] OP_SYNC = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // take input transaction
        logic load_t;     // form azimuth*steps product
        logic scale;      // reciprocal multiply for the divide by 360
        logic load_h;     // start heading divide
        logic div_step;   // one restoring step
        logic update;     // apply operation to position
        logic diff;       // heading and path candidates
        logic pick;       // choose shortest candidate
        logic out_load;   // move result to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

>>> rtl/wpt_ctrl.sv
// ----------------------------------------------------------------------------
// wpt_ctrl
// Sequencer for one transaction: scale, update, divide, compare, output.
// ----------------------------------------------------------------------------
module wpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wpt_pkg::t_sts i_sts,
    output wpt_pkg::t_cmd o_cmd
);
    import wpt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD_T = 9'b000000010,
        S_SCALE  = 9'b000000100,
        S_UPDATE = 9'b000001000,
        S_LOAD_H = 9'b000010000,
        S_DIV_H  = 9'b000100000,
        S_DIFF   = 9'b001000000,
        S_PICK   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD_T;
                end
            end
            S_LOAD_T: begin
                o_cmd.load_t = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_LOAD_H;
            end
            S_LOAD_H: begin
                o_cmd.load_h = 1'b1;
                n_cnt        = CNT_W'(H_STEPS - 1);
                n_state      = S_DIV_H;
            end
            S_DIV_H: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/wpt_dp.sv
// ----------------------------------------------------------------------------
// wpt_dp
// Datapath: position state, reciprocal scaler, restoring heading divider,
// path candidates, output register.
// ----------------------------------------------------------------------------
module wpt_dp #(
    parameter int unsigned POSITION_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wpt_pkg::SPT_W-1:0]   i_cfg_wdata,
    input  wpt_pkg::t_cmd               i_cmd,
    output wpt_pkg::t_sts               o_sts,
    input  logic [wpt_pkg::OP_W-1:0]    i_operation,
    input  logic [wpt_pkg::AZ_W-1:0]    i_azimuth,
    input  logic [wpt_pkg::SPT_W-1:0]   i_load_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [wpt_pkg::SPT_W-1:0]   o_position,
    output logic [wpt_pkg::AZ_W-1:0]    o_heading_degrees,
    output logic [wpt_pkg::STEPS_W-1:0] o_shortest_steps
);
    import wpt_pkg::*;

    localparam int unsigned PB = POSITION_BITS;
    // compare width: holds position+1 and steps_per_turn
    localparam int unsigned EW = ((PB + 1) > SPT_W) ? (PB + 1) : SPT_W;
    // signed width for path candidates
    localparam int unsigned SW = EW + 2;

    logic [OP_W-1:0]    r_op;
    logic [AZ_W-1:0]    r_az;
    logic [SPT_W-1:0]   r_ld;
    logic [SPT_W-1:0]   r_spt;
    logic [PB-1:0]      r_pos;
    logic [SPT_W-1:0]   r_t;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_dsh;
    logic [QUOT_W-1:0]  r_quot;
    logic [AZ_W-1:0]    r_head;
    logic signed [SW-1:0] r_direct, r_cw, r_ccw;
    logic [SW-1:0]      r_ad, r_acw, r_accw;
    logic [STEPS_W-1:0] r_short;
    logic               r_out_valid;
    logic [SPT_W-1:0]   r_out_pos;
    logic [AZ_W-1:0]    r_out_head;
    logic [STEPS_W-1:0] r_out_short;

    // position update
    logic [EW-1:0]      pos_ext, spt_ext, inc_ext, ld_ext;
    logic [PB-1:0]      n_pos;
    // divider step
    logic               div_ge;
    // candidates
    logic signed [SW-1:0] t_s, p_s, r_s, d_dir, d_cw, d_ccw;
    logic [AZ_W-1:0]    n_head;
    logic signed [SW-1:0] n_short;

    assign pos_ext = EW'(r_pos);
    assign spt_ext = EW'(r_spt);
    assign inc_ext = pos_ext + 1'b1;
    assign ld_ext  = EW'(r_ld);

    always_comb begin
        unique case (r_op)
            OP_FWD: begin
                if (inc_ext > spt_ext) begin
                    n_pos = PB'(inc_ext - spt_ext);
                end else begin
                    n_pos = PB'(inc_ext);
                end
            end
            OP_BACK: begin
                if (r_pos == '0) begin
                    n_pos = PB'(r_spt);
                end else begin
                    n_pos = r_pos - 1'b1;
                end
            end
            OP_SYNC: n_pos = PB'(r_t);
            OP_LOAD: n_pos = (ld_ext > spt_ext) ? PB'(r_spt) : PB'(r_ld);
            default: n_pos = r_pos;
        endcase
    end

    assign div_ge = (r_rem >= r_dsh);

    // heading: quotient only valid when position is below steps_per_turn
    always_comb begin
        priority if (r_spt == '0) begin
            n_head = '0;
        end else if (pos_ext >= spt_ext) begin
            n_head = AZ_W'(DEG_PER_TURN);
        end else begin
            n_head = r_quot[AZ_W-1:0];
        end
    end

    assign t_s   = SW'(r_t);
    assign p_s   = SW'(r_pos);
    assign r_s   = SW'(r_spt);
    assign d_dir = t_s - p_s;
    assign d_cw  = p_s + r_s - t_s;
    assign d_ccw = t_s + r_s - p_s;

    // strictly smallest magnitude wins; ties fall back to direct
    always_comb begin
        priority if (r_ad < r_acw && r_ad < r_accw) begin
            n_short = r_direct;
        end else if (r_acw < r_ad && r_acw < r_accw) begin
            n_short = -r_cw;
        end else if (r_accw < r_ad && r_accw < r_acw) begin
            n_short = r_ccw;
        end else begin
            n_short = r_direct;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_az <= (i_azimuth > AZ_W'(DEG_PER_TURN)) ? AZ_W'(DEG_PER_TURN) : i_azimuth;
            r_ld <= i_load_value;
        end
        if (i_cmd.load_t) begin
            r_rem  <= REM_W'(r_az) * REM_W'(r_spt);
        end else if (i_cmd.load_h) begin
            r_rem  <= REM_W'(r_pos) * REM_W'(DEG_PER_TURN);
            r_dsh  <= REM_W'(r_spt) << (H_STEPS - 1);
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[QUOT_W-2:0], div_ge};
            r_dsh  <= r_dsh >> 1;
        end
        // divide by 360: drop the factor 8, then multiply by 1/45
        if (i_cmd.scale) begin
            r_t <= SPT_W'((PROD_W'(r_rem[REM_W-1:3]) * PROD_W'(RECIP_45)) >> RECIP_SHIFT);
        end
        if (i_cmd.diff) begin
            r_head   <= n_head;
            r_direct <= d_dir;
            r_cw     <= d_cw;
            r_ccw    <= d_ccw;
            r_ad     <= d_dir[SW-1]  ? SW'(-d_dir)  : SW'(d_dir);
            r_acw    <= d_cw[SW-1]   ? SW'(-d_cw)   : SW'(d_cw);
            r_accw   <= d_ccw[SW-1]  ? SW'(-d_ccw)  : SW'(d_ccw);
        end
        if (i_cmd.pick) begin
            r_short <= n_short[STEPS_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_pos   <= SPT_W'(r_pos);
            r_out_head  <= r_head;
            r_out_short <= r_short;
        end
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt       <= SPT_W'(1);
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spt <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                r_pos <= n_pos;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_position        = r_out_pos;
    assign o_heading_degrees = r_out_head;
    assign o_shortest_steps  = r_out_short;

endmodule

>>> rtl/wrapping_position_tracker.sv
// ----------------------------------------------------------------------------
// wrapping_position_tracker
// Stepper position tracker over 0..steps_per_turn with heading and
// shortest-path step count to a requested azimuth.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transaction per operation. tuser carries the
//   operation code, tdata the azimuth and the raw load value.
//   Output stream (m_axis): exactly one result transaction per input, in
//   order: new position, heading in degrees, signed shortest step count.
//   Config: i_cfg_we/i_cfg_wdata write steps_per_turn; write only while idle.
// Timing:
//   Each transaction passes through capture, the azimuth*steps product, a
//   reciprocal multiply for the divide by 360, position update, a 9-step
//   restoring divide (position*360/steps), candidate compare in the DIFF and
//   PICK states, output load and return to idle. The heading divide is the
//   longest step. A new input is accepted only once the controller is back
//   in idle.
// Reset:
//   position clears to 0, steps_per_turn returns to 1, output goes empty.
// Stall:
//   the result waits in the output register; the next input is still
//   accepted and processed, and holds only at its own output load until the
//   register frees up.
// ----------------------------------------------------------------------------
module wrapping_position_tracker #(
    parameter int unsigned POSITION_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config
    input  logic                        i_cfg_we,
    input  logic [wpt_pkg::SPT_W-1:0]   i_cfg_wdata,     // steps_per_turn
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [39:0]                 i_s_axis_tdata,  // [8:0] azimuth,
                                                         // [32:9] load_value,
                                                         // [39:33] zero
    input  logic [wpt_pkg::OP_W-1:0]    i_s_axis_tuser,  // [2:0] operation
    // output stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [63:0]                 o_m_axis_tdata   // [23:0] position,
                                                         // [32:24] heading_degrees,
                                                         // [57:33] shortest_steps,
                                                         // [63:58] zero
);
    import wpt_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [SPT_W-1:0]   position;
    logic [AZ_W-1:0]    heading_degrees;
    logic [STEPS_W-1:0] shortest_steps;

    wpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wpt_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (i_s_axis_tuser),
        .i_azimuth         (i_s_axis_tdata[8:0]),
        .i_load_value      (i_s_axis_tdata[32:9]),
        .i_out_ready       (i_m_axis_tready),
        .o_out_valid       (o_m_axis_tvalid),
        .o_position        (position),
        .o_heading_degrees (heading_degrees),
        .o_shortest_steps  (shortest_steps)
    );

    assign o_m_axis_tdata = {6'b0, shortest_steps, heading_degrees, position};

endmodule
